FILE: hdl/kpc_pkg.sv
package kpc_pkg;

    localparam int NUM_KEYS   = 4;
    localparam int TIME_W     = 16;
    localparam int EVENT_W    = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [TIME_W-1:0] SHORT_LIMIT_RESET = 16'd40;
    localparam logic [TIME_W-1:0] STUCK_LIMIT_RESET = 16'd3000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT = 1'b1;

    typedef logic [EVENT_W-1:0] event_t;

    localparam event_t EV_NONE    = 2'd0;
    localparam event_t EV_PRESSED = 2'd1;
    localparam event_t EV_SHORT   = 2'd2;
    localparam event_t EV_LONG    = 2'd3;

    // what one lane reports to the merge stage
    typedef struct packed {
        event_t ev;
        logic   stuck;
    } lane_result_t;

endpackage

FILE: hdl/key_press_classifier_unit.sv
// Channel  | Direction | Handshake             | Word
// ---------+-----------+-----------------------+----------------------------------
// in       | input     | in_valid / in_stall   | time_now, pressed_mask, ack_mask
// out      | output    | out_valid / out_stall | key0..3_event, stuck_mask
// cfg      | input     | cfg_we                | cfg_index, cfg_data
//
// One word per cycle while in_stall is low; a result appears in the cycle after its input word is taken.
// A single output register follows the four key lanes.
// rst_n is asynchronous: all key state clears, limits return to 40 and 3000.
// in_stall is high only while a result sits in the output register and
// out_stall holds it; a word is taken in the same cycle the result leaves.
module key_press_classifier_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [kpc_pkg::TIME_W-1:0]          time_now,
    input  logic [kpc_pkg::NUM_KEYS-1:0]        pressed_mask,
    input  logic [kpc_pkg::NUM_KEYS-1:0]        ack_mask,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [kpc_pkg::EVENT_W-1:0]         key0_event,
    output logic [kpc_pkg::EVENT_W-1:0]         key1_event,
    output logic [kpc_pkg::EVENT_W-1:0]         key2_event,
    output logic [kpc_pkg::EVENT_W-1:0]         key3_event,
    output logic [kpc_pkg::NUM_KEYS-1:0]        stuck_mask,
    // configuration
    input  logic                                cfg_we,
    input  logic [kpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [kpc_pkg::TIME_W-1:0] short_limit_reg;
    logic [kpc_pkg::TIME_W-1:0] stuck_limit_reg;
    logic                       accept;

    kpc_pkg::lane_result_t [kpc_pkg::NUM_KEYS-1:0] lane_res;

    // output register full and held: no room for a new word
    assign in_stall = out_valid & out_stall;
    assign accept   = in_valid & ~in_stall;

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_limit_reg <= kpc_pkg::SHORT_LIMIT_RESET;
            stuck_limit_reg <= kpc_pkg::STUCK_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kpc_pkg::CFG_SHORT_LIMIT: short_limit_reg <= cfg_data;
                kpc_pkg::CFG_STUCK_LIMIT: stuck_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // one lane per key; each lane holds that key's debounce and hold state
    // and presents its next event and stuck flag to the merge stage
    for (genvar k = 0; k < kpc_pkg::NUM_KEYS; k++)
    begin : g_lane
        kpc_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .enable      (accept),
            .level       (pressed_mask[k]),
            .ack         (ack_mask[k]),
            .time_now    (time_now),
            .short_limit (short_limit_reg),
            .stuck_limit (stuck_limit_reg),
            .result      (lane_res[k])
        );
    end

    // merge stage gathers the lanes into one result word
    kpc_merge u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .lane_res   (lane_res),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .key0_event (key0_event),
        .key1_event (key1_event),
        .key2_event (key2_event),
        .key3_event (key3_event),
        .stuck_mask (stuck_mask)
    );

endmodule

FILE: hdl/kpc_lane.sv
module kpc_lane
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              enable,
    input  logic                              level,
    input  logic                              ack,
    input  logic [kpc_pkg::TIME_W-1:0]        time_now,
    input  logic [kpc_pkg::TIME_W-1:0]        short_limit,
    input  logic [kpc_pkg::TIME_W-1:0]        stuck_limit,
    output kpc_pkg::lane_result_t             result
);

    // previous sample is the registered sample_now, seen before the shift
    logic                         sample_now_reg,  sample_now_next;
    logic                         filtered_reg,    filtered_next;
    logic                         stuck_reg,       stuck_next;
    kpc_pkg::event_t              event_reg,       event_next;
    logic [kpc_pkg::TIME_W-1:0]   stamp_reg,       stamp_next;
    logic [kpc_pkg::TIME_W-1:0]   held_reg,        held_next;
    logic [kpc_pkg::TIME_W-1:0]   hold_diff;
    kpc_pkg::event_t              event_acked;

    // wrapping hold time since last released sample
    assign hold_diff   = time_now - stamp_reg;
    assign event_acked = ack ? kpc_pkg::EV_NONE : event_reg;

    always_comb
    begin
        sample_now_next  = level;
        filtered_next    = filtered_reg;
        stuck_next       = stuck_reg;
        event_next       = event_acked;
        stamp_next       = stamp_reg;
        held_next        = held_reg;
        if (!stuck_reg)
        begin
            if (level)
            begin
                if (sample_now_reg)
                begin
                    if (!filtered_reg)
                    begin
                        event_next = kpc_pkg::EV_PRESSED;
                    end
                    filtered_next = 1'b1;
                end
                held_next = hold_diff;
                if (hold_diff > stuck_limit)
                begin
                    sample_now_next  = 1'b0;
                    filtered_next    = 1'b0;
                    event_next       = kpc_pkg::EV_NONE;
                    stuck_next       = 1'b1;
                end
            end
            else
            begin
                stamp_next = time_now;
                if (!sample_now_reg)
                begin
                    if (event_acked == kpc_pkg::EV_PRESSED)
                    begin
                        event_next = (held_reg < short_limit) ? kpc_pkg::EV_SHORT
                                                              : kpc_pkg::EV_LONG;
                    end
                    filtered_next = 1'b0;
                    held_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_now_reg  <= 1'b0;
            filtered_reg    <= 1'b0;
            stuck_reg       <= 1'b0;
            event_reg       <= kpc_pkg::EV_NONE;
            stamp_reg       <= '0;
            held_reg        <= '0;
        end
        else if (enable)
        begin
            sample_now_reg  <= sample_now_next;
            filtered_reg    <= filtered_next;
            stuck_reg       <= stuck_next;
            event_reg       <= event_next;
            stamp_reg       <= stamp_next;
            held_reg        <= held_next;
        end
    end

    assign result.ev    = event_next;
    assign result.stuck = stuck_next;

endmodule

FILE: hdl/kpc_merge.sv
module kpc_merge
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        load,
    input  kpc_pkg::lane_result_t [kpc_pkg::NUM_KEYS-1:0] lane_res,
    input  logic                                        out_stall,
    output logic                                        out_valid,
    output logic [kpc_pkg::EVENT_W-1:0]                 key0_event,
    output logic [kpc_pkg::EVENT_W-1:0]                 key1_event,
    output logic [kpc_pkg::EVENT_W-1:0]                 key2_event,
    output logic [kpc_pkg::EVENT_W-1:0]                 key3_event,
    output logic [kpc_pkg::NUM_KEYS-1:0]                stuck_mask
);

    logic                                   valid_reg, valid_next;
    kpc_pkg::event_t [kpc_pkg::NUM_KEYS-1:0] events_reg;
    logic [kpc_pkg::NUM_KEYS-1:0]           stuck_reg, stuck_merged;

    always_comb
    begin
        for (int k = 0; k < kpc_pkg::NUM_KEYS; k++)
        begin
            stuck_merged[k] = lane_res[k].stuck;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < kpc_pkg::NUM_KEYS; k++)
            begin
                events_reg[k] <= lane_res[k].ev;
            end
            stuck_reg <= stuck_merged;
        end
    end

    assign out_valid  = valid_reg;
    assign key0_event = events_reg[0];
    assign key1_event = events_reg[1];
    assign key2_event = events_reg[2];
    assign key3_event = events_reg[3];
    assign stuck_mask = stuck_reg;

endmodule

FILE: hdl/kpc_checker.sv
module kpc_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [kpc_pkg::EVENT_W-1:0]         key0_event,
    input  logic [kpc_pkg::EVENT_W-1:0]         key1_event,
    input  logic [kpc_pkg::EVENT_W-1:0]         key2_event,
    input  logic [kpc_pkg::EVENT_W-1:0]         key3_event,
    input  logic [kpc_pkg::NUM_KEYS-1:0]        stuck_mask
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(stuck_mask)
            && $stable(key0_event) && $stable(key1_event)
            && $stable(key2_event) && $stable(key3_event))
        else $error("stalled result word changed");

    // input only stalls while the output register is blocked
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output register");

    // stuck flags are sticky across successive result words
    a_stuck_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) |-> (($past(stuck_mask) & ~stuck_mask) == '0))
        else $error("stuck flag cleared without reset");

    // a stuck key reports no event
    a_stuck_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!stuck_mask[0] || key0_event == kpc_pkg::EV_NONE)
            && (!stuck_mask[1] || key1_event == kpc_pkg::EV_NONE)
            && (!stuck_mask[2] || key2_event == kpc_pkg::EV_NONE)
            && (!stuck_mask[3] || key3_event == kpc_pkg::EV_NONE))
        else $error("event reported on stuck key");

endmodule

bind key_press_classifier_unit kpc_checker u_kpc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key0_event (key0_event),
    .key1_event (key1_event),
    .key2_event (key2_event),
    .key3_event (key3_event),
    .stuck_mask (stuck_mask)
);
